/* sv/tbp_pkg.sv */
// Shared types and constants for the tournament branch predictor.
`default_nettype none

package tbp_pkg;

    // 2-bit saturating counter
    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_RESET = 2'd3;
    localparam ctr_t CTR_MAX   = 2'd3;
    localparam ctr_t CTR_MIN   = 2'd0;

    typedef enum logic [1:0] {
        MODE_ALWAYS     = 2'd0,
        MODE_LOCAL      = 2'd1,
        MODE_GSHARE     = 2'd2,
        MODE_TOURNAMENT = 2'd3
    } mode_t;

    typedef struct packed {
        logic [31:0] branch_address;
        logic        branch_taken;
    } branch_t;

    typedef struct packed {
        logic predicted_taken;
        logic local_predicted;
        logic global_predicted;
        logic chooser_picks_global;
        logic prediction_correct;
    } result_t;

    // Counters read from the tables for one branch, plus its outcome
    typedef struct packed {
        ctr_t local_ctr;
        ctr_t gshare_ctr;
        ctr_t chooser_ctr;
        logic taken;
    } lookup_t;

    // Result and write-back values for one branch
    typedef struct packed {
        result_t res;
        ctr_t    local_next;
        ctr_t    gshare_next;
        ctr_t    chooser_next;
        logic    local_we;
        logic    gshare_we;
        logic    chooser_we;
    } train_t;

endpackage

`default_nettype wire

/* sv/tbp_chan_if.sv */
// Valid/ready channel carrying one payload per transfer.
`default_nettype none

interface tbp_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/tbp_train.sv */
// Prediction select and counter/chooser update for one branch.
`default_nettype none

module tbp_train
    import tbp_pkg::*;
(
    input  mode_t   mode,
    input  lookup_t lk,
    output train_t  tr
);

    function automatic ctr_t sat_up(input ctr_t c);
        return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    endfunction

    function automatic ctr_t sat_down(input ctr_t c);
        return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    endfunction

    logic lpred;
    logic gpred;
    logic pick_g;
    logic pred;
    ctr_t chooser_upd;

    assign lpred  = lk.local_ctr[1];
    assign gpred  = lk.gshare_ctr[1];
    assign pick_g = lk.chooser_ctr[1];

    // Select the reported prediction
    always_comb
    begin
        case (mode)
            MODE_LOCAL:      pred = lpred;
            MODE_GSHARE:     pred = gpred;
            MODE_TOURNAMENT: pred = pick_g ? gpred : lpred;
            default:         pred = 1'b1;
        endcase
    end

    // Chooser: move toward the component that was right
    always_comb
    begin
        if (pick_g)
        begin
            if (lk.taken)
                chooser_upd = gpred ? sat_up(lk.chooser_ctr)
                            : (lpred ? sat_down(lk.chooser_ctr) : lk.chooser_ctr);
            else
                chooser_upd = (gpred && !lpred) ? sat_down(lk.chooser_ctr)
                            : sat_up(lk.chooser_ctr);
        end
        else
        begin
            if (lk.taken)
                chooser_upd = lpred ? sat_down(lk.chooser_ctr)
                            : (gpred ? sat_up(lk.chooser_ctr) : lk.chooser_ctr);
            else
                chooser_upd = (lpred && !gpred) ? sat_up(lk.chooser_ctr)
                            : sat_down(lk.chooser_ctr);
        end
    end

    // Pack result and write-back values
    always_comb
    begin
        tr.res.predicted_taken      = pred;
        tr.res.local_predicted      = lpred;
        tr.res.global_predicted     = gpred;
        tr.res.chooser_picks_global = pick_g;
        tr.res.prediction_correct   = (pred == lk.taken);
        tr.local_next   = lk.taken ? sat_up(lk.local_ctr) : sat_down(lk.local_ctr);
        tr.gshare_next  = lk.taken ? sat_up(lk.gshare_ctr) : sat_down(lk.gshare_ctr);
        tr.chooser_next = chooser_upd;
        tr.local_we     = (mode == MODE_LOCAL) || (mode == MODE_TOURNAMENT);
        tr.gshare_we    = (mode == MODE_GSHARE) || (mode == MODE_TOURNAMENT);
        tr.chooser_we   = (mode == MODE_TOURNAMENT);
    end

endmodule

`default_nettype wire

/* sv/tournament_branch_predictor.sv */
// Top level: tournament predictor with local-history and gshare components.
// A branch accepted in idle moves through lookup and update; its result is
// registered at write-back. The next branch waits for the serial lookup chain
// (history read, then local counter read, then write-back of the enabled tables).
// The result register frees the output side; a stalled result holds write-back.
// Reset: a clearing pass over max(COUNTER_ENTRIES, HISTORY_SLOTS) entries fills
// the tables; no branch is accepted until it ends. Mode resets to always taken.
`default_nettype none

module tournament_branch_predictor
    import tbp_pkg::*;
#(
    parameter int COUNTER_ENTRIES = 1024,
    parameter int HISTORY_SLOTS   = 128
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tbp_chan_if.sink   cfg,
    tbp_chan_if.sink   branch,
    tbp_chan_if.source result
);

    localparam int IDX_W     = $clog2(COUNTER_ENTRIES);
    localparam int SLOT_W    = $clog2(HISTORY_SLOTS);
    localparam int CLR_DEPTH = (COUNTER_ENTRIES > HISTORY_SLOTS) ? COUNTER_ENTRIES
                                                                 : HISTORY_SLOTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    typedef logic [IDX_W-1:0] idx_t;

    // Table storage
    idx_t hist_mem    [HISTORY_SLOTS];
    ctr_t local_mem   [COUNTER_ENTRIES];
    ctr_t gshare_mem  [COUNTER_ENTRIES];
    ctr_t chooser_mem [COUNTER_ENTRIES];

    state_t           state_reg, state_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    mode_t            mode_reg, mode_next;
    idx_t             ghist_reg, ghist_next;
    logic             rvalid_reg, rvalid_next;
    result_t          res_reg;

    logic [SLOT_W-1:0] slot_reg;
    idx_t              cidx_reg;
    idx_t              gidx_reg;
    logic              taken_reg;
    idx_t              hist_rd_reg;
    ctr_t              local_rd_reg;
    ctr_t              gshare_rd_reg;
    ctr_t              chooser_rd_reg;

    logic    accept;
    logic    upd_fire;
    logic    clr_done;
    logic    clearing;
    idx_t    cidx_in;
    idx_t    hist_shifted;
    lookup_t lk;
    train_t  tr;

    assign cfg.ready    = 1'b1;
    assign branch.ready = (state_reg == ST_IDLE);
    assign result.valid = rvalid_reg;
    assign result.data  = res_reg;

    assign accept   = branch.valid && branch.ready;
    assign upd_fire = (state_reg == ST_UPDATE) && (!rvalid_reg || result.ready);
    assign clearing = (state_reg == ST_CLEAR);
    assign clr_done = (clr_reg == CLR_W'(CLR_DEPTH - 1));
    assign cidx_in  = branch.data.branch_address[IDX_W-1:0];
    assign hist_shifted = {hist_rd_reg[IDX_W-2:0], taken_reg};

    assign lk.local_ctr   = local_rd_reg;
    assign lk.gshare_ctr  = gshare_rd_reg;
    assign lk.chooser_ctr = chooser_rd_reg;
    assign lk.taken       = taken_reg;

    tbp_train u_train (
        .mode (mode_reg),
        .lk   (lk),
        .tr   (tr)
    );

    // Sequence: clear, accept, lookup, update
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                if (clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Mode, global history and result valid
    always_comb
    begin
        mode_next   = cfg.valid ? cfg.data : mode_reg;
        ghist_next  = ghist_reg;
        rvalid_next = rvalid_reg;
        if (upd_fire && tr.gshare_we)
            ghist_next = {ghist_reg[IDX_W-2:0], taken_reg};
        if (upd_fire)
            rvalid_next = 1'b1;
        else if (result.ready)
            rvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            mode_reg   <= MODE_ALWAYS;
            ghist_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            mode_reg   <= mode_next;
            ghist_reg  <= ghist_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Capture the branch on transfer and load the result on write-back
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg  <= branch.data.branch_address[SLOT_W-1:0];
            cidx_reg  <= cidx_in;
            gidx_reg  <= cidx_in ^ ghist_reg;
            taken_reg <= branch.data.branch_taken;
        end
        if (upd_fire)
            res_reg <= tr.res;
    end

    // Local history table: read on transfer, write back or clear
    always_ff @(posedge clk)
    begin
        if (accept)
            hist_rd_reg <= hist_mem[branch.data.branch_address[SLOT_W-1:0]];
        if (clearing)
            hist_mem[clr_reg[SLOT_W-1:0]] <= '0;
        else if (upd_fire && tr.local_we)
            hist_mem[slot_reg] <= hist_shifted;
    end

    // Local counter table: read once the history is known
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOOKUP)
            local_rd_reg <= local_mem[hist_rd_reg];
        if (clearing)
            local_mem[clr_reg[IDX_W-1:0]] <= CTR_RESET;
        else if (upd_fire && tr.local_we)
            local_mem[hist_rd_reg] <= tr.local_next;
    end

    // Gshare counter table
    always_ff @(posedge clk)
    begin
        if (accept)
            gshare_rd_reg <= gshare_mem[cidx_in ^ ghist_reg];
        if (clearing)
            gshare_mem[clr_reg[IDX_W-1:0]] <= CTR_RESET;
        else if (upd_fire && tr.gshare_we)
            gshare_mem[gidx_reg] <= tr.gshare_next;
    end

    // Chooser table
    always_ff @(posedge clk)
    begin
        if (accept)
            chooser_rd_reg <= chooser_mem[cidx_in];
        if (clearing)
            chooser_mem[clr_reg[IDX_W-1:0]] <= CTR_RESET;
        else if (upd_fire && tr.chooser_we)
            chooser_mem[cidx_reg] <= tr.chooser_next;
    end

`ifndef SYNTH
    // A transfer always starts the lookup chain
    a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("branch transfer did not start lookup");

    // Write-back always presents a result
    a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> result.valid)
        else $error("write-back without result");

    // Always-taken mode leaves global history untouched
    a_mode0_ghist: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && mode_reg == MODE_ALWAYS) |=> $stable(ghist_reg))
        else $error("global history moved in always-taken mode");

    // Clearing pass hands over to idle when the sweep ends
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing && clr_done) |=> state_reg == ST_IDLE)
        else $error("clearing pass did not end in idle");
`endif

endmodule

`default_nettype wire
